[rtl/core/desp_pkg.sv]
// Shared types and constants of the detector event stream parser.
package desp_pkg;

  // Input word: one payload byte with its event flags
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_event;
    logic       end_of_cycle;
  } desp_in_t;

  // Result word
  typedef struct packed {
    logic [2:0]  kind;
    logic [10:0] device_id;
    logic [6:0]  wire_res;
    logic [11:0] drift_time;
    logic [5:0]  dev_mask;
    logic [11:0] trig_cause;
    logic [17:0] gate_len;
    logic [2:0]  error_code;
    logic        last;
  } desp_res_t;

  // Result kinds
  localparam logic [2:0] KIND_PROP  = 3'd0;
  localparam logic [2:0] KIND_DRIFT = 3'd1;
  localparam logic [2:0] KIND_TRIG  = 3'd2;
  localparam logic [2:0] KIND_END   = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_HDR_BIT   = 3'd1;
  localparam logic [2:0] ERR_DRIFT_BIT = 3'd2;
  localparam logic [2:0] ERR_DIGIT     = 3'd3;
  localparam logic [2:0] ERR_TRUNC     = 3'd4;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_PROP_TYPE  = 2'd0;
  localparam logic [1:0] REG_DRIFT_TYPE = 2'd1;
  localparam logic [1:0] REG_TRIG_TYPE  = 2'd2;

  // Register reset values
  localparam logic [2:0] PROP_TYPE_RST  = 3'd0;
  localparam logic [2:0] DRIFT_TYPE_RST = 3'd1;
  localparam logic [2:0] TRIG_TYPE_RST  = 3'd2;

  // Counter id that closes an end-of-cycle block
  localparam logic [15:0] LAST_COUNTER = 16'h7F4F;

  // Parser phase, one-hot
  typedef enum logic [10:0] {
    PH_HDR_HI     = 11'b000_0000_0001,
    PH_HDR_LO     = 11'b000_0000_0010,
    PH_PROP       = 11'b000_0000_0100,
    PH_DRIFT_WIRE = 11'b000_0000_1000,
    PH_DRIFT_TIME = 11'b000_0001_0000,
    PH_TRIG       = 11'b000_0010_0000,
    PH_EOC_CYCLE  = 11'b000_0100_0000,
    PH_EOC_PAD    = 11'b000_1000_0000,
    PH_EOC_ID     = 11'b001_0000_0000,
    PH_EOC_VAL    = 11'b010_0000_0000,
    PH_SKIP       = 11'b100_0000_0000
  } desp_phase_t;

  // Place a 6-bit digit at digit position sel of an 18-bit field
  function automatic logic [17:0] place_digit(input logic [5:0] d, input logic [1:0] sel);
    logic [17:0] r;
    r = '0;
    case (sel)
      2'd0: r = {12'b0, d};
      2'd1: r = {6'b0, d, 6'b0};
      2'd2: r = {d, 12'b0};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/detector_event_stream_parser.sv]
// Top level of the detector event stream parser: byte parser, result queue, register port.

// Takes the payload of one detector event one byte word per cycle on the data
// channel and returns decoded hits, trigger info, event-end and error words on
// the result channel. Each byte is held in one input register and decoded in a
// single pass; its results (at most two: a hit or trigger word followed by an
// event end or a truncation error) go into a four-entry result queue. A new
// byte is taken every cycle as long as the queue holds at most two words, so
// the sustained rate is one byte per cycle, limited by the result side taking
// one word per cycle. Each byte is registered in the input register before its
// results are written to the result queue. A malformed byte yields one error
// word and every further byte of that event is dropped without a result. The
// three block type codes are to be written by the user through the APB port
// at byte addresses 0, 4 and 8 only while the block is idle; it does not enforce
// this. When codes coincide, proportional wins over drift and drift over trigger.
module detector_event_stream_parser (
  input  logic                 clk,
  input  logic                 rst,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // byte channel
  input  logic                 data_valid,
  output logic                 data_ready,
  input  desp_pkg::desp_in_t   data,
  // result channel
  output logic                 result_valid,
  input  logic                 result_ready,
  output desp_pkg::desp_res_t  result
);
  import desp_pkg::*;

  // ---------------- register port ----------------
  logic [2:0] prop_code;
  logic [2:0] drift_code;
  logic [2:0] trig_code;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_code  <= PROP_TYPE_RST;
      drift_code <= DRIFT_TYPE_RST;
      trig_code  <= TRIG_TYPE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP_TYPE:  prop_code  <= pwdata[2:0];
        REG_DRIFT_TYPE: drift_code <= pwdata[2:0];
        REG_TRIG_TYPE:  trig_code  <= pwdata[2:0];
        default: ; // unmapped address, write ignored
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PROP_TYPE:  prdata = {29'b0, prop_code};
      REG_DRIFT_TYPE: prdata = {29'b0, drift_code};
      REG_TRIG_TYPE:  prdata = {29'b0, trig_code};
      default:        prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  logic        stg_valid;
  desp_in_t    stg;
  logic        stg_adv;
  logic [QAW:0] q_cnt;

  // Decode only when the queue has room for two words.
  assign stg_adv    = stg_valid && (q_cnt <= (QAW+1)'(QDEPTH - 2));
  assign data_ready = !stg_valid || stg_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (data_ready) begin
      stg_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_ready && data_valid) begin
      stg <= data;
    end
  end

  // ---------------- parser state ----------------
  desp_phase_t phase, phase_next;
  logic [7:0]  header_high, header_high_next;
  logic [10:0] block_device, block_device_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [17:0] field_acc, field_acc_next;      // drift time / gate time digits
  logic [5:0]  held_wire, held_wire_next;
  logic [17:0] held_mask_cause, held_mask_cause_next;
  logic [15:0] cnt_id, cnt_id_next;
  logic        drop_to_end, drop_to_end_next;

  // decode outputs
  logic        data_vld;
  desp_res_t   data_res;
  logic        tail_vld;
  desp_res_t   tail_res;
  logic [1:0]  push_n;
  desp_res_t   slot0, slot1;

  always_comb begin
    logic [7:0]  b;
    logic        bad_digit;
    logic [2:0]  err;
    logic [15:0] hdr;
    logic [2:0]  btype;
    logic [2:0]  dc_m3;
    logic        may_end;

    b         = stg.data_byte;
    bad_digit = |b[7:6];
    err       = ERR_NONE;
    hdr       = {header_high, b};
    btype     = hdr[14:12];
    dc_m3     = digit_count - 3'd3;
    may_end   = 1'b0;

    phase_next           = phase;
    header_high_next     = header_high;
    block_device_next    = block_device;
    digit_count_next     = digit_count;
    field_acc_next       = field_acc;
    held_wire_next       = held_wire;
    held_mask_cause_next = held_mask_cause;
    cnt_id_next          = cnt_id;
    drop_to_end_next     = drop_to_end;

    data_vld = 1'b0;
    data_res = '0;
    tail_vld = 1'b0;
    tail_res = '0;

    if (drop_to_end) begin
      // rest of a bad event: silent until its last byte
      if (stg.last_of_event) begin
        drop_to_end_next = 1'b0;
        phase_next       = PH_HDR_HI;
        digit_count_next = '0;
      end
    end else begin
      if (b[7] && (phase == PH_PROP || phase == PH_DRIFT_WIRE || phase == PH_SKIP)) begin
        // marker byte ends the block data and opens the next header
        header_high_next = b;
        phase_next       = PH_HDR_LO;
      end else begin
        case (phase)
          PH_HDR_HI: begin
            if (!b[7]) begin
              err = ERR_HDR_BIT;
            end else begin
              header_high_next = b;
              phase_next       = PH_HDR_LO;
            end
          end
          PH_HDR_LO: begin
            block_device_next    = {hdr[11:8], hdr[6:0]};
            digit_count_next     = '0;
            field_acc_next       = '0;
            held_mask_cause_next = '0;
            if (btype == prop_code) begin
              phase_next = PH_PROP;
            end else if (btype == drift_code) begin
              phase_next = PH_DRIFT_WIRE;
            end else if (btype == trig_code) begin
              phase_next = stg.end_of_cycle ? PH_EOC_CYCLE : PH_TRIG;
            end else begin
              phase_next = PH_SKIP;
            end
          end
          PH_PROP: begin
            data_vld           = 1'b1;
            data_res.kind      = KIND_PROP;
            data_res.device_id = block_device;
            data_res.wire_res  = b[6:0];
          end
          PH_DRIFT_WIRE: begin
            if (!b[6]) begin
              err = ERR_DRIFT_BIT;
            end else begin
              held_wire_next   = b[5:0];
              digit_count_next = '0;
              field_acc_next   = '0;
              phase_next       = PH_DRIFT_TIME;
            end
          end
          PH_DRIFT_TIME: begin
            if (bad_digit) begin
              err = ERR_DIGIT;
            end else begin
              field_acc_next = field_acc | place_digit(b[5:0], {1'b0, digit_count[0]});
              if (digit_count >= 3'd1) begin
                data_vld            = 1'b1;
                data_res.kind       = KIND_DRIFT;
                data_res.device_id  = block_device;
                data_res.wire_res   = {1'b0, held_wire};
                data_res.drift_time = field_acc_next[11:0];
                digit_count_next    = '0;
                phase_next          = PH_DRIFT_WIRE;
              end else begin
                digit_count_next = digit_count + 3'd1;
              end
            end
          end
          PH_TRIG: begin
            if (bad_digit) begin
              err = ERR_DIGIT;
            end else begin
              // mask and cause digits first, then gate time digits
              if (digit_count < 3'd3) begin
                held_mask_cause_next = held_mask_cause
                                       | place_digit(b[5:0], digit_count[1:0]);
              end else begin
                field_acc_next = field_acc | place_digit(b[5:0], dc_m3[1:0]);
              end
              if (digit_count >= 3'd5) begin
                data_vld            = 1'b1;
                data_res.kind       = KIND_TRIG;
                data_res.device_id  = block_device;
                data_res.dev_mask   = held_mask_cause_next[5:0];
                data_res.trig_cause = held_mask_cause_next[17:6];
                data_res.gate_len   = field_acc_next;
                digit_count_next    = '0;
                phase_next          = PH_HDR_HI;
              end else begin
                digit_count_next = digit_count + 3'd1;
              end
            end
          end
          PH_EOC_CYCLE: begin
            if (bad_digit) begin
              err = ERR_DIGIT;
            end else if (digit_count >= 3'd1) begin
              digit_count_next = '0;
              phase_next       = PH_EOC_PAD;
            end else begin
              digit_count_next = digit_count + 3'd1;
            end
          end
          PH_EOC_PAD: begin
            if (digit_count >= 3'd2) begin
              digit_count_next = '0;
              phase_next       = PH_EOC_ID;
            end else begin
              digit_count_next = digit_count + 3'd1;
            end
          end
          PH_EOC_ID: begin
            if (digit_count == 3'd0) begin
              cnt_id_next      = {8'b0, b};
              digit_count_next = 3'd1;
            end else begin
              cnt_id_next      = {b, cnt_id[7:0]};
              digit_count_next = '0;
              phase_next       = PH_EOC_VAL;
            end
          end
          PH_EOC_VAL: begin
            if (bad_digit) begin
              err = ERR_DIGIT;
            end else if (digit_count >= 3'd3) begin
              digit_count_next = '0;
              phase_next       = (cnt_id == LAST_COUNTER) ? PH_SKIP : PH_EOC_ID;
            end else begin
              digit_count_next = digit_count + 3'd1;
            end
          end
          PH_SKIP: ;
          default: phase_next = PH_HDR_HI;
        endcase
      end

      may_end = (phase_next == PH_HDR_HI) || (phase_next == PH_PROP) ||
                (phase_next == PH_DRIFT_WIRE) || (phase_next == PH_SKIP);

      if (err != ERR_NONE) begin
        tail_vld            = 1'b1;
        tail_res.kind       = KIND_ERROR;
        tail_res.error_code = err;
        phase_next          = PH_HDR_HI;
        digit_count_next    = '0;
        drop_to_end_next    = !stg.last_of_event;
      end else if (stg.last_of_event) begin
        tail_vld = 1'b1;
        if (may_end) begin
          tail_res.kind = KIND_END;
        end else begin
          tail_res.kind       = KIND_ERROR;
          tail_res.error_code = ERR_TRUNC;
        end
        phase_next       = PH_HDR_HI;
        digit_count_next = '0;
      end
    end
  end

  // Pack the byte's results in order; last marks the final one.
  always_comb begin
    slot0  = data_vld ? data_res : tail_res;
    slot1  = tail_res;
    push_n = {1'b0, data_vld} + {1'b0, tail_vld};
    slot0.last = !(data_vld && tail_vld);
    slot1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR_HI;
      drop_to_end <= 1'b0;
      digit_count <= '0;
    end else if (stg_adv) begin
      phase       <= phase_next;
      drop_to_end <= drop_to_end_next;
      digit_count <= digit_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_high     <= '0;
      block_device    <= '0;
      field_acc       <= '0;
      held_wire       <= '0;
      held_mask_cause <= '0;
      cnt_id          <= '0;
    end else if (stg_adv) begin
      header_high     <= header_high_next;
      block_device    <= block_device_next;
      field_acc       <= field_acc_next;
      held_wire       <= held_wire_next;
      held_mask_cause <= held_mask_cause_next;
      cnt_id          <= cnt_id_next;
    end
  end

  // ---------------- result queue ----------------
  desp_res_t       q_mem [QDEPTH];
  logic [QAW-1:0]  q_wr;
  logic [QAW-1:0]  q_rd;
  logic            q_pop;
  logic [1:0]      q_push;

  assign q_push       = stg_adv ? push_n : 2'd0;
  assign q_pop        = result_valid && result_ready;
  assign result_valid = (q_cnt != '0);
  assign result       = q_mem[q_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= '0;
      q_rd  <= '0;
      q_cnt <= '0;
    end else begin
      q_wr  <= q_wr + QAW'(q_push);
      q_rd  <= q_rd + QAW'(q_pop);
      q_cnt <= q_cnt + (QAW+1)'(q_push) - (QAW+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push != 2'd0) begin
      q_mem[q_wr] <= slot0;
    end
    if (q_push == 2'd2) begin
      q_mem[q_wr + QAW'(1)] <= slot1;
    end
  end

endmodule

[dv/desp_result_checker.sv]
// Result checker of the detector event stream parser: byte decoder model and word compare.
`timescale 1ns / 1ps

module desp_result_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  input  logic                data_valid,
  input  logic                data_ready,
  input  desp_pkg::desp_in_t  data,
  input  logic                result_valid,
  input  logic                result_ready,
  input  desp_pkg::desp_res_t result,
  output int                  fail_count,
  output int                  pending_words,
  output int                  parsed_bytes,
  output int                  words_checked
);
  import desp_pkg::*;

  // type codes as last written
  logic [2:0]  prop_code, drift_code, trig_code;

  // decoder state
  desp_phase_t phase;
  logic [7:0]  hdr_hi_q;
  logic [2:0]  blk_type;
  logic [10:0] blk_dev;
  logic [2:0]  digit_n;
  logic [23:0] accum;
  logic [5:0]  wire_hold;
  logic [17:0] mask_cause;
  logic [15:0] cnt_id;
  logic        dropping;

  desp_res_t   expected_words[$];
  int          fail_cnt, parsed_cnt, checked_cnt;

  function automatic desp_res_t make_word(logic [2:0] kind, logic [10:0] dev,
                                          logic [6:0] wire_no, logic [11:0] tm,
                                          logic [5:0] mask, logic [11:0] cause,
                                          logic [17:0] gate, logic [2:0] code);
    desp_res_t r;
    r.kind       = kind;
    r.device_id  = dev;
    r.wire_res   = wire_no;
    r.drift_time = tm;
    r.dev_mask   = mask;
    r.trig_cause = cause;
    r.gate_len   = gate;
    r.error_code = code;
    r.last       = 1'b0;
    return r;
  endfunction

  task automatic decode_byte(input desp_in_t w);
    logic [7:0]  b;
    logic [15:0] hdr;
    logic [2:0]  err;
    desp_res_t   caused[$];
    b   = w.data_byte;
    err = ERR_NONE;
    if (dropping) begin
      if (w.last_of_event) begin
        dropping = 1'b0;
        phase    = PH_HDR_HI;
        digit_n  = '0;
      end
      return;
    end
    parsed_cnt++;
    // a byte with bit 7 set opens a new block wherever block data may end
    if (b[7] && (phase == PH_PROP || phase == PH_DRIFT_WIRE || phase == PH_SKIP)) begin
      hdr_hi_q = b;
      phase    = PH_HDR_LO;
    end else begin
      case (phase)
        PH_HDR_HI: begin
          if (!b[7]) err = ERR_HDR_BIT;
          else begin
            hdr_hi_q = b;
            phase    = PH_HDR_LO;
          end
        end
        PH_HDR_LO: begin
          hdr        = {hdr_hi_q, b};
          blk_type   = hdr[14:12];
          blk_dev    = {hdr[11:8], hdr[6:0]};
          digit_n    = '0;
          accum      = '0;
          mask_cause = '0;
          if (blk_type == prop_code) phase = PH_PROP;
          else if (blk_type == drift_code) phase = PH_DRIFT_WIRE;
          else if (blk_type == trig_code) phase = w.end_of_cycle ? PH_EOC_CYCLE : PH_TRIG;
          else phase = PH_SKIP;
        end
        PH_PROP: begin
          caused.insert(caused.size(),
                        make_word(KIND_PROP, blk_dev, b[6:0], '0, '0, '0, '0, ERR_NONE));
        end
        PH_DRIFT_WIRE: begin
          if (!b[6]) err = ERR_DRIFT_BIT;
          else begin
            wire_hold = b[5:0];
            digit_n   = '0;
            accum     = '0;
            phase     = PH_DRIFT_TIME;
          end
        end
        PH_DRIFT_TIME: begin
          if (b[7:6] != 2'b00) err = ERR_DIGIT;
          else begin
            accum = accum | (24'(b) << (6 * int'(digit_n[0])));
            if (digit_n >= 3'd1) begin
              caused.insert(caused.size(),
                            make_word(KIND_DRIFT, blk_dev, {1'b0, wire_hold}, accum[11:0],
                                      '0, '0, '0, ERR_NONE));
              digit_n = '0;
              phase   = PH_DRIFT_WIRE;
            end else digit_n++;
          end
        end
        PH_TRIG: begin
          if (b[7:6] != 2'b00) err = ERR_DIGIT;
          else begin
            if (digit_n < 3'd3) mask_cause = mask_cause | (18'(b) << (6 * int'(digit_n)));
            else accum = accum | (24'(b) << (6 * ((int'(digit_n) - 3) & 3)));
            if (digit_n >= 3'd5) begin
              caused.insert(caused.size(),
                            make_word(KIND_TRIG, blk_dev, '0, '0, mask_cause[5:0],
                                      mask_cause[17:6], accum[17:0], ERR_NONE));
              digit_n = '0;
              phase   = PH_HDR_HI;
            end else digit_n++;
          end
        end
        PH_EOC_CYCLE: begin
          if (b[7:6] != 2'b00) err = ERR_DIGIT;
          else if (digit_n >= 3'd1) begin
            digit_n = '0;
            phase   = PH_EOC_PAD;
          end else digit_n++;
        end
        PH_EOC_PAD: begin
          if (digit_n >= 3'd2) begin
            digit_n = '0;
            phase   = PH_EOC_ID;
          end else digit_n++;
        end
        PH_EOC_ID: begin
          if (digit_n == 3'd0) begin
            cnt_id  = {8'h00, b};
            digit_n = 3'd1;
          end else begin
            cnt_id  = {b, cnt_id[7:0]};
            digit_n = '0;
            phase   = PH_EOC_VAL;
          end
        end
        PH_EOC_VAL: begin
          if (b[7:6] != 2'b00) err = ERR_DIGIT;
          else if (digit_n >= 3'd3) begin
            digit_n = '0;
            phase   = (cnt_id == LAST_COUNTER) ? PH_SKIP : PH_EOC_ID;
          end else digit_n++;
        end
        PH_SKIP: ;
        default: phase = PH_HDR_HI;
      endcase
    end

    if (err != ERR_NONE) begin
      caused.insert(caused.size(), make_word(KIND_ERROR, '0, '0, '0, '0, '0, '0, err));
      phase   = PH_HDR_HI;
      digit_n = '0;
      if (!w.last_of_event) dropping = 1'b1;
    end else if (w.last_of_event) begin
      if (phase == PH_HDR_HI || phase == PH_PROP || phase == PH_DRIFT_WIRE || phase == PH_SKIP)
        caused.insert(caused.size(),
                      make_word(KIND_END, '0, '0, '0, '0, '0, '0, ERR_NONE));
      else
        caused.insert(caused.size(),
                      make_word(KIND_ERROR, '0, '0, '0, '0, '0, '0, ERR_TRUNC));
      phase   = PH_HDR_HI;
      digit_n = '0;
    end

    if (caused.size() > 0) caused[caused.size() - 1].last = 1'b1;
    foreach (caused[i]) expected_words.insert(expected_words.size(), caused[i]);
  endtask

  task automatic note_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic check_word(input desp_res_t got);
    desp_res_t want;
    if (expected_words.size() == 0) begin
      $error("result word with none expected: kind %0d code %0d", got.kind, got.error_code);
      fail_cnt++;
      return;
    end
    want = expected_words.pop_front();
    checked_cnt++;
    note_field("kind",       32'(want.kind),       32'(got.kind));
    note_field("device_id",  32'(want.device_id),  32'(got.device_id));
    note_field("wire_res",   32'(want.wire_res),   32'(got.wire_res));
    note_field("drift_time", 32'(want.drift_time), 32'(got.drift_time));
    note_field("dev_mask",   32'(want.dev_mask),   32'(got.dev_mask));
    note_field("trig_cause", 32'(want.trig_cause), 32'(got.trig_cause));
    note_field("gate_len",   32'(want.gate_len),   32'(got.gate_len));
    note_field("error_code", 32'(want.error_code), 32'(got.error_code));
    note_field("last",       32'(want.last),       32'(got.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      prop_code  = PROP_TYPE_RST;
      drift_code = DRIFT_TYPE_RST;
      trig_code  = TRIG_TYPE_RST;
      phase      = PH_HDR_HI;
      hdr_hi_q   = '0;
      blk_type   = '0;
      blk_dev    = '0;
      digit_n    = '0;
      accum      = '0;
      wire_hold  = '0;
      mask_cause = '0;
      cnt_id     = '0;
      dropping   = 1'b0;
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_PROP_TYPE:  prop_code  = pwdata[2:0];
          REG_DRIFT_TYPE: drift_code = pwdata[2:0];
          REG_TRIG_TYPE:  trig_code  = pwdata[2:0];
          default: ;
        endcase
      end
      if (data_valid && data_ready) decode_byte(data);
      if (result_valid && result_ready) check_word(result);
    end
    fail_count    <= fail_cnt;
    pending_words <= expected_words.size();
    parsed_bytes  <= parsed_cnt;
    words_checked <= checked_cnt;
  end

endmodule

[dv/tb_top.sv]
// Testbench top of the detector event stream parser: clock, reset, register and byte stimulus.
`timescale 1ns / 1ps

module tb_top;
  import desp_pkg::*;

  localparam int CYCLE_LIMIT   = 250000;
  localparam int RANDOM_BYTES  = 400;   // parsed bytes per type-code setting
  localparam int N_SETTINGS    = 5;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [3:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        data_valid   = 1'b0;
  logic        data_ready;
  desp_in_t    data         = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  desp_res_t   result;

  // no-idle stretch: both sides run flat out while set
  logic        steady       = 1'b0;

  int          fail_count, pending_words, parsed_bytes, words_checked;
  int          cycle_count  = 0;
  int          events_sent  = 0;
  int          events_broken = 0;

  // stimulus-side copy of the type codes, used to shape block contents
  logic [2:0]  cfg_prop, cfg_drift, cfg_trig;

  // payload bytes of the event being built
  logic [7:0]  ev_bytes[$];

  detector_event_stream_parser dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data         (data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  desp_result_checker result_chk (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .data_valid    (data_valid),
    .data_ready    (data_ready),
    .data          (data),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .parsed_bytes  (parsed_bytes),
    .words_checked (words_checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Result side back-pressure: ready drops with a chance of roughly 9 in 100,
  // never during the steady stretch.
  always @(posedge clk) begin
    result_ready <= steady || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Hard stop in case the block hangs or drops words.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("run stopped at cycle limit, %0d result words still outstanding", pending_words);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // APB write: setup phase, then access phase held until pready; psel then
  // drops before returning so back-to-back writes never re-raise psel in the same step.
  task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // One byte word on the data channel. A one-cycle gap is inserted ahead
  // of about 9 words in 100 outside the steady stretch; otherwise valid
  // stays high straight into the next word.
  task automatic send_byte(input desp_in_t w);
    if (!steady && $urandom_range(99) < 9) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data       <= w;
    data_valid <= 1'b1;
    do @(posedge clk); while (!data_ready);
  endtask

  task automatic send_event(input logic eoc);
    desp_in_t w;
    for (int i = 0; i < ev_bytes.size(); i++) begin
      w.data_byte     = ev_bytes[i];
      w.last_of_event = (i == ev_bytes.size() - 1);
      w.end_of_cycle  = eoc;
      send_byte(w);
    end
  endtask

  // Wait until every predicted word has come back, then keep clocking the
  // parser in case a trailing byte is still in flight without a result.
  task automatic drain();
    data_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_digit();
    return {2'b00, 6'($urandom_range(63))};
  endfunction

  function automatic void add_byte(input logic [7:0] v);
    ev_bytes.insert(ev_bytes.size(), v);
  endfunction

  // Well-formed event: one to four device blocks, each with a random type
  // (one of the three codes or an unused value), random device id and a
  // random but legal body for the block's effective kind. Priority of the
  // codes mirrors the parser: prop over drift over trigger.
  task automatic build_event(input logic eoc);
    logic [2:0]  t;
    logic [10:0] id;
    ev_bytes.delete();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(3))
        0: t = cfg_prop;
        1: t = cfg_drift;
        2: t = cfg_trig;
        default: begin
          t = 3'($urandom_range(7));
          while (t == cfg_prop || t == cfg_drift || t == cfg_trig) t = 3'($urandom_range(7));
        end
      endcase
      id = 11'($urandom_range(2047));
      // header: top bit set, type, id[10:7]; low byte bit 7 is don't-care
      add_byte({1'b1, t, id[10:7]});
      add_byte({1'($urandom_range(1)), id[6:0]});
      if (t == cfg_prop) begin
        repeat ($urandom_range(5)) add_byte({1'b0, 7'($urandom_range(127))});
      end else if (t == cfg_drift) begin
        repeat ($urandom_range(4)) begin
          add_byte({2'b01, 6'($urandom_range(63))});
          repeat (2) add_byte(rand_digit());
        end
      end else if (t == cfg_trig && !eoc) begin
        // mask, cause (2 digits), gate time (3 digits)
        repeat (6) add_byte(rand_digit());
      end else if (t == cfg_trig) begin
        // end-of-cycle: cycle digits, pad, counter records, closing id, tail
        repeat (2) add_byte(rand_digit());
        repeat (3) add_byte(8'($urandom_range(255)));
        repeat ($urandom_range(2)) begin
          repeat (2) add_byte(8'($urandom_range(255)));
          repeat (4) add_byte(rand_digit());
        end
        add_byte(LAST_COUNTER[7:0]);
        add_byte(LAST_COUNTER[15:8]);
        repeat (4) add_byte(rand_digit());
        repeat ($urandom_range(2)) add_byte({1'b0, 7'($urandom_range(127))});
      end else begin
        // unknown type: body is skipped
        repeat ($urandom_range(3)) add_byte({1'b0, 7'($urandom_range(127))});
      end
    end
  endtask

  // Mostly clean events; the rest get one byte smashed, are cut short at
  // a random point, or are replaced by pure noise.
  task automatic run_event();
    logic eoc;
    int   r;
    eoc = ($urandom_range(99) < 25);
    build_event(eoc);
    r = $urandom_range(99);
    if (r < 8) begin
      ev_bytes[$urandom_range(ev_bytes.size() - 1)] = 8'($urandom_range(255));
    end else if (r < 14) begin
      ev_bytes = ev_bytes[0:$urandom_range(ev_bytes.size() - 1)];
    end else if (r < 18) begin
      ev_bytes.delete();
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
    end
    if (r < 18) events_broken++;
    events_sent++;
    send_event(eoc);
  endtask

  task automatic program_codes(input int setting);
    case (setting)
      0: {cfg_prop, cfg_drift, cfg_trig} = {PROP_TYPE_RST, DRIFT_TYPE_RST, TRIG_TYPE_RST};
      1: {cfg_prop, cfg_drift, cfg_trig} = {3'd7, 3'd0, 3'd3};   // extremes
      2: {cfg_prop, cfg_drift, cfg_trig} = {3'd5, 3'd5, 3'd0};   // prop shadows drift
      3: {cfg_prop, cfg_drift, cfg_trig} = {3'd4, 3'd7, 3'd7};   // drift shadows trigger
      default: begin
        cfg_prop  = 3'($urandom_range(7));
        cfg_drift = 3'($urandom_range(7));
        cfg_trig  = 3'($urandom_range(7));
      end
    endcase
    write_reg(REG_PROP_TYPE,  cfg_prop);
    write_reg(REG_DRIFT_TYPE, cfg_drift);
    write_reg(REG_TRIG_TYPE,  cfg_trig);
  endtask

  // Directed events, run with the reset type codes (prop 0, drift 1, trig 2).
  task automatic directed_events();
    // header top bit missing; the rest of the event is dropped
    ev_bytes = '{8'h00, 8'h81};
    send_event(1'b0);
    // prop block, device id 2047 with header low bit 7 set, hits 0 and 127
    ev_bytes = '{8'h8F, 8'hFF, 8'h00, 8'h7F};
    send_event(1'b0);
    // drift hit, wire 63, time 4095; hit and event end on the last byte
    ev_bytes = '{8'h90, 8'h00, 8'h7F, 8'h3F, 8'h3F};
    send_event(1'b0);
    // drift block whose wire-position byte has bit 7 set: it opens a new prop block header instead
    ev_bytes = '{8'h90, 8'h80, 8'h3F};
    send_event(1'b0);
    // trigger block, every digit at its maximum
    ev_bytes = '{8'hA0, 8'h00, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F};
    send_event(1'b0);
    // trigger digit with its top bits set
    ev_bytes = '{8'hA0, 8'h00, 8'hC0};
    send_event(1'b0);
    // event ends inside a header: truncated
    ev_bytes = '{8'h80};
    send_event(1'b0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int s = 0; s < N_SETTINGS; s++) begin
      program_codes(s);
      if (s == 0) directed_events();
      steady <= (s == 1);
      while (parsed_bytes < RANDOM_BYTES * (s + 1)) run_event();
      drain();
    end
    steady <= 1'b0;
    repeat (8) @(posedge clk);

    $display("Covered %0d events (%0d deliberately broken) over %0d type-code settings.",
             events_sent, events_broken, N_SETTINGS);
    $display("Decoded %0d payload bytes and checked %0d result words.",
             parsed_bytes, words_checked);
    if (fail_count == 0 && pending_words == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
